// File: design/bdps_pkg.sv
// package: widths, records, register codes and constants for the best-detection selector
`timescale 1ns / 1ps
package bdps_pkg;

    localparam int NUM_SLOTS  = 4;
    localparam int SLOT_W     = 2;
    localparam int CLASS_W    = 8;
    localparam int CONF_W     = 16;
    localparam int COORD_W    = 12;
    localparam int AREA_W     = 24;
    localparam int CENTER_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // box coordinates are kept to this many bits
    localparam int COORD_BITS = 12;
    localparam logic [COORD_W-1:0] COORD_MASK = (COORD_BITS >= COORD_W) ?
        {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);

    // smallest box that may qualify
    localparam logic [COORD_W-1:0] MIN_DET_W = COORD_W'(4);
    localparam logic [COORD_W-1:0] MIN_DET_H = COORD_W'(4);

    localparam logic [CONF_W-1:0] THR_RESET = CONF_W'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOT0_CLASS     = 3'd0,
        REG_SLOT0_THRESHOLD = 3'd1,
        REG_SLOT1_CLASS     = 3'd2,
        REG_SLOT1_THRESHOLD = 3'd3,
        REG_SLOT2_CLASS     = 3'd4,
        REG_SLOT2_THRESHOLD = 3'd5,
        REG_SLOT3_CLASS     = 3'd6,
        REG_SLOT3_THRESHOLD = 3'd7
    } cfg_reg_t;

    // one registered detection
    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [CONF_W-1:0]  conf;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [AREA_W-1:0]  area;
    } det_t;

    // what one slot holds
    typedef struct packed {
        logic               found;
        logic [CONF_W-1:0]  conf;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        logic [AREA_W-1:0]  area;
    } slot_rec_t;

endpackage

// File: design/best_detection_per_class_select.sv
// top level: config registers, input register, four slots and the result buffer
//
//  channel  | signals                                   | beat moves
//  ---------+-------------------------------------------+-------------------------------
//  input    | in_valid / in_ready + detection fields    | one detection or end marker
//  result   | out_valid / out_ready + result fields     | one slot result, four a frame
//  config   | cfg_we, cfg_index, cfg_data               | one register write, no wait
//
// One input beat per cycle: a beat lands in the input register, the slots
// compare and update from that register. An end-of-frame beat copies
// the four slots into the result buffer, which drains in four result beats.
// A following frame is taken at full rate while the buffer drains; only an
// end-of-frame beat waits if the buffer still holds the previous frame.
// Reset clears all slots, the buffer and loads the default class ids and thresholds.
`timescale 1ns / 1ps
module best_detection_per_class_select (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bdps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdps_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            has_detection,
    input  logic [bdps_pkg::CLASS_W-1:0]    det_class,
    input  logic [bdps_pkg::CONF_W-1:0]     det_confidence,
    input  logic [bdps_pkg::COORD_W-1:0]    box_x,
    input  logic [bdps_pkg::COORD_W-1:0]    box_y,
    input  logic [bdps_pkg::COORD_W-1:0]    box_w,
    input  logic [bdps_pkg::COORD_W-1:0]    box_h,
    input  logic                            last_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bdps_pkg::SLOT_W-1:0]     slot,
    output logic                            found,
    output logic [bdps_pkg::CONF_W-1:0]     best_confidence,
    output logic [bdps_pkg::COORD_W-1:0]    out_x,
    output logic [bdps_pkg::COORD_W-1:0]    out_y,
    output logic [bdps_pkg::COORD_W-1:0]    out_w,
    output logic [bdps_pkg::COORD_W-1:0]    out_h,
    output logic [bdps_pkg::AREA_W-1:0]     out_area,
    output logic [bdps_pkg::CENTER_W-1:0]   center_x2,
    output logic [bdps_pkg::CENTER_W-1:0]   center_y2,
    output logic                            last_out
);
    import bdps_pkg::*;

    logic [CLASS_W-1:0] cls_reg [NUM_SLOTS];
    logic [CONF_W-1:0]  thr_reg [NUM_SLOTS];

    logic      s1_valid_reg;
    logic      s1_has_reg;
    logic      s1_last_reg;
    det_t      s1_det_reg;
    det_t      det_next;
    logic      s1_go;
    logic      emit_free;
    logic      in_take;
    slot_rec_t recs [NUM_SLOTS];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                cls_reg[i] <= CLASS_W'(i);
                thr_reg[i] <= THR_RESET;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SLOT0_CLASS:     cls_reg[0] <= cfg_data[CLASS_W-1:0];
                REG_SLOT0_THRESHOLD: thr_reg[0] <= cfg_data[CONF_W-1:0];
                REG_SLOT1_CLASS:     cls_reg[1] <= cfg_data[CLASS_W-1:0];
                REG_SLOT1_THRESHOLD: thr_reg[1] <= cfg_data[CONF_W-1:0];
                REG_SLOT2_CLASS:     cls_reg[2] <= cfg_data[CLASS_W-1:0];
                REG_SLOT2_THRESHOLD: thr_reg[2] <= cfg_data[CONF_W-1:0];
                REG_SLOT3_CLASS:     cls_reg[3] <= cfg_data[CLASS_W-1:0];
                REG_SLOT3_THRESHOLD: thr_reg[3] <= cfg_data[CONF_W-1:0];
                default: ;
            endcase
        end
    end

    // input register handshake: an end-of-frame beat waits for a free buffer
    assign s1_go    = s1_valid_reg && (!s1_last_reg || emit_free);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_take  = in_valid && in_ready;

    // masked box and its area
    always_comb
    begin
        det_next.cls  = det_class;
        det_next.conf = det_confidence;
        det_next.x    = box_x & COORD_MASK;
        det_next.y    = box_y & COORD_MASK;
        det_next.w    = box_w & COORD_MASK;
        det_next.h    = box_h & COORD_MASK;
        det_next.area = AREA_W'(det_next.w) * AREA_W'(det_next.h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_has_reg  <= has_detection;
            s1_last_reg <= last_in;
            s1_det_reg  <= det_next;
        end
    end

    // four parallel slots
    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_slot
        bdps_slot u_slot (
            .clk   (clk),
            .rst_n (rst_n),
            .cls   (cls_reg[g]),
            .thr   (thr_reg[g]),
            .det   (s1_det_reg),
            .load  (s1_go && s1_has_reg),
            .clear (s1_go && s1_last_reg),
            .rec   (recs[g])
        );
    end

    // result buffer
    bdps_emit u_emit (
        .clk             (clk),
        .rst_n           (rst_n),
        .snap            (s1_go && s1_last_reg),
        .recs            (recs),
        .free            (emit_free),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .slot            (slot),
        .found           (found),
        .best_confidence (best_confidence),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_w           (out_w),
        .out_h           (out_h),
        .out_area        (out_area),
        .center_x2       (center_x2),
        .center_y2       (center_y2),
        .last_out        (last_out)
    );

endmodule

// File: design/bdps_slot.sv
// one compare-and-keep slot: qualifies a detection and keeps the best one of the frame
`timescale 1ns / 1ps
module bdps_slot (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bdps_pkg::CLASS_W-1:0] cls,
    input  logic [bdps_pkg::CONF_W-1:0]  thr,
    input  bdps_pkg::det_t             det,
    input  logic                       load,
    input  logic                       clear,
    output bdps_pkg::slot_rec_t        rec
);
    import bdps_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    slot_rec_t keep_reg;
    logic      qualify;
    logic      take;

    // qualification against this slot's class, threshold and minimum box
    assign qualify = (det.cls == cls) && (det.conf >= thr) &&
                     (det.w >= MIN_DET_W) && (det.h >= MIN_DET_H);

    // higher confidence wins, larger area breaks a tie, else the earlier stays
    assign take = load && qualify &&
                  (!valid_reg || (det.conf > keep_reg.conf) ||
                   ((det.conf == keep_reg.conf) && (det.area > keep_reg.area)));

    // record after this beat, before any end-of-frame clear
    always_comb
    begin
        rec       = keep_reg;
        rec.found = valid_reg;
        if (take)
        begin
            rec.found = 1'b1;
            rec.conf  = det.conf;
            rec.x     = det.x;
            rec.y     = det.y;
            rec.w     = det.w;
            rec.h     = det.h;
            rec.area  = det.area;
        end
    end

    assign valid_next = clear ? 1'b0 : rec.found;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // kept detection payload
    always_ff @(posedge clk)
    begin
        if (take)
            keep_reg <= rec;
    end

endmodule

// File: design/bdps_emit.sv
// result buffer: captures the four slots at end of frame and drains them one beat at a time
`timescale 1ns / 1ps
module bdps_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          snap,
    input  bdps_pkg::slot_rec_t           recs [bdps_pkg::NUM_SLOTS],
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bdps_pkg::SLOT_W-1:0]   slot,
    output logic                          found,
    output logic [bdps_pkg::CONF_W-1:0]   best_confidence,
    output logic [bdps_pkg::COORD_W-1:0]  out_x,
    output logic [bdps_pkg::COORD_W-1:0]  out_y,
    output logic [bdps_pkg::COORD_W-1:0]  out_w,
    output logic [bdps_pkg::COORD_W-1:0]  out_h,
    output logic [bdps_pkg::AREA_W-1:0]   out_area,
    output logic [bdps_pkg::CENTER_W-1:0] center_x2,
    output logic [bdps_pkg::CENTER_W-1:0] center_y2,
    output logic                          last_out
);
    import bdps_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    logic              busy_reg;
    logic              busy_next;
    logic [SLOT_W-1:0] cnt_reg;
    logic [SLOT_W-1:0] cnt_next;
    slot_rec_t         buf_reg [NUM_SLOTS];
    slot_rec_t         cur;
    logic              done;

    assign done = busy_reg && out_ready && (cnt_reg == LAST_SLOT);
    assign free = !busy_reg || done;

    // drain control
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg && out_ready)
        begin
            cnt_next = cnt_reg + SLOT_W'(1);
            if (cnt_reg == LAST_SLOT)
                busy_next = 1'b0;
        end
        if (snap)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // snapshot of all slots
    always_ff @(posedge clk)
    begin
        if (snap)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                buf_reg[i] <= recs[i];
        end
    end

    // result fields, zero for a slot that found nothing
    assign cur             = buf_reg[cnt_reg];
    assign out_valid       = busy_reg;
    assign slot            = cnt_reg;
    assign found           = cur.found;
    assign best_confidence = cur.found ? cur.conf : '0;
    assign out_x           = cur.found ? cur.x : '0;
    assign out_y           = cur.found ? cur.y : '0;
    assign out_w           = cur.found ? cur.w : '0;
    assign out_h           = cur.found ? cur.h : '0;
    assign out_area        = cur.found ? cur.area : '0;
    assign center_x2       = cur.found ?
        ({cur.x, 1'b0} + {1'b0, cur.w}) : '0;
    assign center_y2       = cur.found ?
        ({cur.y, 1'b0} + {1'b0, cur.h}) : '0;
    assign last_out        = (cnt_reg == LAST_SLOT);

endmodule

// File: design/bdps_checker.sv
// port checker for the best-detection selector and its bind
`timescale 1ns / 1ps
module bdps_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [bdps_pkg::SLOT_W-1:0]     slot,
    input logic                            found,
    input logic [bdps_pkg::CONF_W-1:0]     best_confidence,
    input logic [bdps_pkg::COORD_W-1:0]    out_w,
    input logic [bdps_pkg::COORD_W-1:0]    out_h,
    input logic [bdps_pkg::AREA_W-1:0]     out_area,
    input logic                            last_out
);
    import bdps_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(found))
        else $error("result beat changed while stalled");

    // results of a frame come in slot order without gaps
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_out |=>
            out_valid && (slot == $past(slot) + SLOT_W'(1)))
        else $error("slot results out of order");

    // the last beat of a frame is the final slot
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_out == (slot == SLOT_W'(NUM_SLOTS - 1))))
        else $error("last_out not on final slot");

    // an empty slot reports zeros
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (best_confidence == '0) && (out_area == '0))
        else $error("empty slot with nonzero result");

    // a kept box met the minimum size
    a_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (out_w >= MIN_DET_W) && (out_h >= MIN_DET_H))
        else $error("kept box below minimum size");

endmodule

bind best_detection_per_class_select bdps_checker u_bdps_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .slot            (slot),
    .found           (found),
    .best_confidence (best_confidence),
    .out_w           (out_w),
    .out_h           (out_h),
    .out_area        (out_area),
    .last_out        (last_out)
);
